// ===== hw/rtl/ordered_unique_set_table_macros.svh =====
// Assertion macros for the ordered unique set table checker.
// No dependencies; included by the checker file only.
`ifndef ORDERED_UNIQUE_SET_TABLE_MACROS_SVH
`define ORDERED_UNIQUE_SET_TABLE_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define OSUT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define OSUT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/osut_pkg.sv =====
// Package for the ordered unique set table: codes, sequencer states, cell control.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package osut_pkg;

	localparam int OSUT_CAPACITY = 16;
	localparam int OSUT_KEY_BITS = 32;

	// Control fields to the cells are sized for the largest capacity (256).
	localparam int CTRL_W = 9;

	localparam int REQ_W    = 2;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;
	localparam int KEY_W    = 32;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_ABSENT    = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_FULL      = 3'd5,
		ST_QUERY     = 3'd6
	} osut_status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_ENC,
		SEQ_UPD
	} osut_state_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		logic              cmp_en;   // capture compare result
		logic              wr_en;    // append the key
		logic [CTRL_W-1:0] wr_idx;   // cell that takes the appended key
		logic              sh_en;    // close the gap left by a removal
		logic [CTRL_W-1:0] sh_from;  // first cell that takes its neighbour's key
		logic [CTRL_W-1:0] cnt;      // entries held before the update
	} osut_ctrl_t;

endpackage

// ===== hw/rtl/osut_cell.sv =====
// One storage cell of the set table: holds one key, compares, shifts down.
// Depends on osut_pkg.
`timescale 1ns / 1ps

module osut_cell
	import osut_pkg::*;
#(
	parameter int IDX      = 0,
	parameter int KEY_BITS = OSUT_KEY_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  osut_ctrl_t          ctrl,
	input  logic [KEY_BITS-1:0] key_in,
	input  logic [KEY_BITS-1:0] nbr_in,
	output logic [KEY_BITS-1:0] entry_out,
	output logic                hit_out
);

	logic [KEY_BITS-1:0] entry_q;
	logic                hit_q;
	logic                occupied;
	logic                shift_here;

	assign occupied   = CTRL_W'(IDX) < ctrl.cnt;
	assign shift_here = ctrl.sh_en && (CTRL_W'(IDX) >= ctrl.sh_from)
	                    && (CTRL_W'(IDX + 1) < ctrl.cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			hit_q <= occupied && (entry_q == key_in);
		end
	end

	// Key store: no reset, only entries below the count are ever looked at.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en && (ctrl.wr_idx == CTRL_W'(IDX))) begin
			entry_q <= key_in;
		end else if (shift_here) begin
			entry_q <= nbr_in;
		end
	end

	assign entry_out = entry_q;
	assign hit_out   = hit_q;

endmodule

// ===== hw/rtl/osut_enc.sv =====
// Hit encoder: turns the row of per-cell hit flags into an index and a found flag.
// Depends on osut_pkg. Keys are unique, so at most one flag is ever set.
`timescale 1ns / 1ps

module osut_enc
	import osut_pkg::*;
#(
	parameter int N     = OSUT_CAPACITY,
	parameter int IDX_W = $clog2(OSUT_CAPACITY)
) (
	input  logic [N-1:0]     hits,
	output logic             found,
	output logic [IDX_W-1:0] pos
);

	logic [N-1:0] masked [IDX_W];

	// Bit b of the index is the OR of the hits of cells whose index has bit b set.
	for (genvar b = 0; b < IDX_W; b++) begin : g_bit
		for (genvar i = 0; i < N; i++) begin : g_cell
			assign masked[b][i] = (((i >> b) & 1) == 1) ? hits[i] : 1'b0;
		end
		assign pos[b] = |masked[b];
	end

	assign found = |hits;

endmodule

// ===== hw/rtl/ordered_unique_set_table.sv =====
// Top level of the ordered unique set table: row of key cells, encoder, sequencer.
// Depends on osut_pkg, osut_cell and osut_enc.
//
//  channel  | valid     | stall     | word fields
//  ---------+-----------+-----------+------------------------------------------
//  request  | in_valid  | in_stall  | req_type, key
//  result   | out_valid | out_stall | status, found, position, entry_count
//
// Each word passes three steps: accept with compare in every cell, encode of
// the hit row into an index, then the update of the cells and the count.
// in_stall is high from the cycle after an accept until the update is done.
// The update waits while a previous result is held in the output register
// and out_stall is high.
// Reset clears the count, the sequencer and the output valid; key cells are not
// reset and need no clearing pass, as occupancy follows from the count alone.
`timescale 1ns / 1ps

module ordered_unique_set_table
	import osut_pkg::*;
#(
	parameter int CAPACITY = OSUT_CAPACITY,
	parameter int KEY_BITS = OSUT_KEY_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [KEY_W-1:0]    key,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic                found,
	output logic [POS_W-1:0]    position,
	output logic [COUNT_W-1:0]  entry_count
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// Only the low bits of the 32-bit key field take part.
	localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

	osut_state_t state_q, state_d;

	logic [REQ_W-1:0]    req_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] key_ext;
	logic [KEY_BITS-1:0] key_cells;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [IDX_W-1:0]    pos_q;
	logic                found_q;

	logic [KEY_BITS-1:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0] hits;
	logic [IDX_W-1:0]    enc_pos;
	logic                enc_found;

	osut_ctrl_t   ctrl;
	osut_status_t status_d;
	logic         accept;
	logic         out_free;
	logic         load;
	logic         do_insert;
	logic         do_remove;

	logic                out_valid_q;
	osut_status_t        status_q;
	logic                found_out_q;
	logic [IDX_W-1:0]    pos_out_q;
	logic [CNT_W-1:0]    count_out_q;
	logic [IDX_W+3:0]    pos_x;
	logic [CNT_W+4:0]    cnt_x;

	assign in_stall = (state_q != SEQ_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign load     = (state_q == SEQ_UPD) && out_free;

	assign key_ext   = KEY_BITS'(key[KW-1:0]);
	// Compare runs against the incoming key at accept; writes use the held key.
	assign key_cells = (state_q == SEQ_IDLE) ? key_ext : key_q;

	// ---- request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			key_q <= key_ext;
		end
	end

	// ---- row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0] nbr;
		if (i == CAPACITY - 1) begin : g_last
			assign nbr = entry_w[i];
		end else begin : g_mid
			assign nbr = entry_w[i+1];
		end
		osut_cell #(
			.IDX      (i),
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.key_in    (key_cells),
			.nbr_in    (nbr),
			.entry_out (entry_w[i]),
			.hit_out   (hits[i])
		);
	end

	osut_enc #(
		.N     (CAPACITY),
		.IDX_W (IDX_W)
	) u_enc (
		.hits  (hits),
		.found (enc_found),
		.pos   (enc_pos)
	);

	always_ff @(posedge clk) begin
		if (state_q == SEQ_ENC) begin
			pos_q   <= enc_pos;
			found_q <= enc_found;
		end
	end

	// ---- sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: if (accept) state_d = SEQ_ENC;
			SEQ_ENC:  state_d = SEQ_UPD;
			SEQ_UPD:  if (out_free) state_d = SEQ_IDLE;
			default:  state_d = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---- sequencer: decision and cell control
	always_comb begin
		do_insert = 1'b0;
		do_remove = 1'b0;
		count_d   = count_q;
		priority if (req_q == REQ_INSERT) begin
			if (found_q) begin
				status_d = ST_DUPLICATE;
			end else if (count_q == CNT_W'(CAPACITY)) begin
				status_d = ST_FULL;
			end else begin
				status_d  = ST_INSERTED;
				do_insert = 1'b1;
				count_d   = CNT_W'(count_q + 1'b1);
			end
		end else if (req_q == REQ_REMOVE) begin
			if (count_q == '0) begin
				status_d = ST_EMPTY;
			end else if (found_q) begin
				status_d  = ST_REMOVED;
				do_remove = 1'b1;
				count_d   = CNT_W'(count_q - 1'b1);
			end else begin
				status_d = ST_ABSENT;
			end
		end else begin
			// unused request code behaves as a query
			status_d = ST_QUERY;
		end

		ctrl.cmp_en  = accept;
		ctrl.wr_en   = load && do_insert;
		ctrl.wr_idx  = CTRL_W'(count_q);
		ctrl.sh_en   = load && do_remove;
		ctrl.sh_from = CTRL_W'(pos_q);
		ctrl.cnt     = CTRL_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= count_d;
		end
	end

	// ---- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q    <= status_d;
			found_out_q <= found_q;
			pos_out_q   <= found_q ? pos_q : '0;
			count_out_q <= count_d;
		end
	end

	// Wide capacities report only the low bits of index and count.
	assign pos_x = (IDX_W + 4)'(pos_out_q);
	assign cnt_x = (CNT_W + 5)'(count_out_q);

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found       = found_out_q;
	assign position    = pos_x[POS_W-1:0];
	assign entry_count = cnt_x[COUNT_W-1:0];

endmodule

// ===== hw/rtl/osut_checker.sv =====
// Port-level checker for the ordered unique set table, bound to the top level.
// Depends on osut_pkg and ordered_unique_set_table_macros.svh.
`timescale 1ns / 1ps
`include "ordered_unique_set_table_macros.svh"

module osut_checker
	import osut_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic [REQ_W-1:0]    req_type,
	input logic [KEY_W-1:0]    key,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic                found,
	input logic [POS_W-1:0]    position,
	input logic [COUNT_W-1:0]  entry_count
);

	// held result word does not move
	`OSUT_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(status) && $stable(found) && $stable(position) && $stable(entry_count), "result word changed while stalled")

	// one word at a time: busy right after an accept
	`OSUT_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall |=> in_stall, "request taken while a word is in flight")

	// found must agree with the status code
	`OSUT_ASSERT(a_found_status, clk, arst_n, out_valid |-> (found == ((status == ST_DUPLICATE) || (status == ST_REMOVED) || ((status == ST_QUERY) && found))), "found flag disagrees with status")

	// no match means index zero
	`OSUT_ASSERT(a_pos_zero, clk, arst_n, out_valid && !found |-> position == '0, "nonzero index without a match")

	// empty report only on an empty set
	`OSUT_ASSERT(a_empty_count, clk, arst_n, out_valid && (status == ST_EMPTY) |-> entry_count == '0, "empty reported with entries held")

endmodule

bind ordered_unique_set_table osut_checker u_osut_checker (.*);

// ===== dv/ordered_unique_set_table_checker.sv =====
// Checker for the ordered unique set table: mirrors the stored keys, predicts each result word
// and compares it field by field. Depends on osut_pkg; instantiated beside the block by the bench.
`timescale 1ns / 1ps

module ordered_unique_set_table_checker
	import osut_pkg::*;
#(
	parameter int CAPACITY = OSUT_CAPACITY,
	parameter int KEY_BITS = OSUT_KEY_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [KEY_W-1:0]    key,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [STATUS_W-1:0] status,
	input  logic                found,
	input  logic [POS_W-1:0]    position,
	input  logic [COUNT_W-1:0]  entry_count,
	output int                  mismatches,
	output int                  outstanding
);

	typedef struct packed {
		osut_status_t       status;
		logic               found;
		logic [POS_W-1:0]   position;
		logic [COUNT_W-1:0] entry_count;
	} set_result_t;

	logic [KEY_BITS-1:0] held_keys [CAPACITY];
	int                  held_count = 0;
	set_result_t         awaited_results [$];

	task automatic report_mismatch(input string what);
		$display("%0t ns: set table mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
	endtask

	// lowest stored index holding the key, -1 if none
	function automatic int find_held(input logic [KEY_BITS-1:0] k);
		for (int i = 0; i < held_count; i++)
			if (held_keys[i] == k)
				return i;
		return -1;
	endfunction

	// applies one request word to the mirrored set and returns its result word
	function automatic set_result_t apply_request(input logic [REQ_W-1:0] req,
			input logic [KEY_W-1:0] raw);
		logic [KEY_BITS-1:0] k;
		int                  hit_at;
		set_result_t         r;
		k      = KEY_BITS'(raw);
		hit_at = -1;
		if (req == REQ_INSERT) begin
			hit_at = find_held(k);
			if (hit_at >= 0) begin
				r.status = ST_DUPLICATE;
			end else if (held_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				held_keys[held_count] = k;
				held_count++;
				r.status = ST_INSERTED;
			end
		end else if (req == REQ_REMOVE) begin
			if (held_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				hit_at = find_held(k);
				if (hit_at >= 0) begin
					for (int i = hit_at; i + 1 < held_count; i++)
						held_keys[i] = held_keys[i + 1];
					held_count--;
					r.status = ST_REMOVED;
				end else begin
					r.status = ST_ABSENT;
				end
			end
		end else begin
			hit_at   = find_held(k);
			r.status = ST_QUERY;
		end
		r.found       = (hit_at >= 0);
		r.position    = (hit_at >= 0) ? POS_W'(hit_at) : '0;
		r.entry_count = COUNT_W'(held_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		set_result_t want;
		if (!arst_n) begin
			held_count = 0;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			// results first, so a word arriving with an empty store is never masked
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result word with no request waiting");
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 32'(status), 32'(want.status));
					check_field("found", 32'(found), 32'(want.found));
					check_field("position", 32'(position), 32'(want.position));
					check_field("entry_count", 32'(entry_count), 32'(want.entry_count));
				end
			end
			if (in_valid && !in_stall)
				awaited_results.insert(awaited_results.size(), apply_request(req_type, key));
			outstanding <= awaited_results.size();
		end
	end

endmodule

// ===== dv/ordered_unique_set_table_tb.sv =====
// Bench top for the ordered unique set table: clock, reset, request words and the verdict.
// Depends on osut_pkg, the block and ordered_unique_set_table_checker.
`timescale 1ns / 1ps

module ordered_unique_set_table_tb;
	import osut_pkg::*;

	localparam int CAPACITY     = OSUT_CAPACITY;
	localparam int KEY_BITS     = OSUT_KEY_BITS;
	localparam int RANDOM_WORDS = 800;
	// pool wider than the table, so full sets and absent keys both turn up
	localparam int POOL_SIZE    = 24;
	localparam int RUN_LIMIT_NS = 4_000_000;

	// request codes beyond the package's two
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [REQ_W-1:0]    req_type    = '0;
	logic [KEY_W-1:0]    key         = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [POS_W-1:0]    position;
	logic [COUNT_W-1:0]  entry_count;

	int mismatches;
	int outstanding;

	// set during a stretch of the random part: neither side idles then
	bit quiet_spell = 1'b0;

	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	// random keys sent as inserts; removes pull them back out
	logic [KEY_W-1:0] stray_keys [$];

	always #10 clk = ~clk;

	ordered_unique_set_table #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.key(key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found(found),
		.position(position),
		.entry_count(entry_count)
	);

	ordered_unique_set_table_checker #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.key(key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found(found),
		.position(position),
		.entry_count(entry_count),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// result side: stalls in roughly one cycle in ten, never during the quiet spell
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= !quiet_spell && ($urandom_range(99) < 10);
	end

	// Presents one request word and returns at the edge that takes it.
	// An optional gap goes ahead of the word; since the block stalls after
	// each accept until its update is done, short gaps land inside the stall
	// and longer ones past it.
	task automatic send_word(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] k);
		if (!quiet_spell && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_type <= req;
		key      <= k;
		in_valid <= 1'b1;
		// in_stall read here is its value just before this edge
		do @(posedge clk); while (in_stall);
	endtask

	// Edge cases: empty set, both key extremes, duplicate, the spare code,
	// absent key, head removal with shift, filling to capacity, last slot,
	// insert into a full set and a removal from the middle.
	task automatic directed_words();
		send_word(REQ_REMOVE, 32'h0000_0000);   // remove from an empty set
		send_word(REQ_QUERY, 32'hFFFF_FFFF);    // query on an empty set
		send_word(REQ_INSERT, 32'h0000_0000);
		send_word(REQ_INSERT, 32'hFFFF_FFFF);
		send_word(REQ_INSERT, 32'h0000_0000);   // duplicate ignored
		send_word(REQ_QUERY, 32'hFFFF_FFFF);    // hit at slot 1
		send_word(REQ_SPARE, 32'hFFFF_FFFF);    // spare code behaves as a query
		send_word(REQ_REMOVE, 32'h0000_0005);   // absent key
		send_word(REQ_REMOVE, 32'h0000_0000);   // head goes, all-ones moves to slot 0
		for (int i = 0; i < CAPACITY - 1; i++)
			send_word(REQ_INSERT, 32'h1 << ((2 * i) % 32));
		send_word(REQ_QUERY, 32'h1 << ((2 * (CAPACITY - 2)) % 32));  // last slot
		send_word(REQ_INSERT, 32'hA5A5_A5A5);   // set is full
		send_word(REQ_REMOVE, 32'h1 << 10);     // middle removal, tail shifts down
	endtask

	// Random words in spells of forty: a filling spell leans on inserts, a
	// draining spell on removes, a mixed spell balances them. Keys come mostly
	// from a small pool so hits are common; some are fully random.
	task automatic random_words(input int n);
		int               spell;
		int               pick;
		int               ins_cut;
		int               rem_cut;
		logic [REQ_W-1:0] req;
		logic [KEY_W-1:0] k;
		spell = 2;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				spell = $urandom_range(2);
			quiet_spell = (i >= 300 && i < 420);
			ins_cut = (spell == 0) ? 65 : (spell == 1) ? 15 : 35;
			rem_cut = ins_cut + ((spell == 0) ? 15 : (spell == 1) ? 65 : 35);
			pick    = $urandom_range(99);
			if (pick < ins_cut)
				req = REQ_INSERT;
			else if (pick < rem_cut)
				req = REQ_REMOVE;
			else if (pick < 97)
				req = REQ_QUERY;
			else
				req = REQ_SPARE;
			if (req == REQ_REMOVE && stray_keys.size() != 0 && $urandom_range(3) == 0) begin
				k = stray_keys.pop_front();
			end else if ($urandom_range(99) < 8) begin
				k = $urandom;
				if (req == REQ_INSERT)
					stray_keys.insert(stray_keys.size(), k);
			end else begin
				k = key_pool[$urandom_range(POOL_SIZE - 1)];
			end
			send_word(req, k);
		end
		quiet_spell = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_words();
		random_words(RANDOM_WORDS);
		in_valid <= 1'b0;
		// one edge so the checker's count includes the last accepted word
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		// then wait on, to catch any stray result word
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("** ordered_unique_set_table: PASSED **");
		else
			$display("** ordered_unique_set_table: FAILED **");
		$finish;
	end

	// hard stop, many times the slowest legal run
	initial begin
		#(RUN_LIMIT_NS);
		$display("** ordered_unique_set_table: FAILED **");
		$finish;
	end

endmodule
